// ----- hw/rtl/ptss_pkg.sv -----
// Shared types and constants of the periodic task slot scheduler.
// Used by ptss_cell, ptss_seq and periodic_task_slot_scheduler_top; no dependencies.
`default_nettype none

package ptss_pkg;

  localparam int SLOT_COUNT  = 8;   // 1 .. 64
  localparam int MAX_RESULTS = 8;   // fires per poll
  localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W      = 6;
  localparam int VAL_W       = 16;
  localparam int IN_W        = 59;
  localparam int OUT_W       = 41;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_POLL    = 3'd1,
    OP_ADD     = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_DISABLE = 3'd4,
    OP_QUERY   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IDLE     = 2'd1,
    ST_FULL     = 2'd2,
    ST_INACTIVE = 2'd3
  } status_e;

  // input word, opcode in the low bits
  typedef struct packed {
    logic [VAL_W-1:0]        handler;
    logic signed [VAL_W-1:0] argument;
    logic [VAL_W-1:0]        period;
    logic [7:0]              task_index;
    op_e                     opcode;
  } item_t;

  // result word without the end-of-item mark, status in the low bits
  typedef struct packed {
    logic                    is_active;
    logic [VAL_W-1:0]        fired_handler;
    logic signed [VAL_W-1:0] fired_argument;
    logic [SLOT_W-1:0]       slot;
    status_e                 status;
  } res_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    start;   // launch the scan token into the first cell
    logic                    step;    // move the scan token one cell
    logic                    clear;   // drop a stray token
    logic                    tick;
    logic                    poll;
    logic                    add;
    logic                    en_val;
    logic [VAL_W-1:0]        period;
    logic signed [VAL_W-1:0] argument;
    logic [VAL_W-1:0]        handler;
  } ctl_t;

  // per-cell report; data fields are zero unless the cell fires
  typedef struct packed {
    logic                    active;
    logic                    fire;
    logic                    take;
    logic signed [VAL_W-1:0] argument;
    logic [VAL_W-1:0]        handler;
  } cell_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ptss_cell.sv -----
// One task slot of the scheduler chain: slot state plus the scan token stage.
// Depends on ptss_pkg.
`default_nettype none

module ptss_cell
  import ptss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire ctl_t  ctl_i,
  input  wire logic  tok_i,    // token from the previous cell
  input  wire logic  sel_i,    // enable/disable aimed at this slot
  output      logic  tok_o,
  output      cell_t stat_o
);

  logic                    tok_q;
  logic                    active_q;
  logic                    enabled_q;
  logic [VAL_W-1:0]        period_q;
  logic [VAL_W-1:0]        remaining_q;
  logic signed [VAL_W-1:0] argument_q;
  logic [VAL_W-1:0]        handler_q;
  logic                    take;
  logic                    fire;

  assign take = tok_q && ctl_i.step && ctl_i.add && !active_q;
  assign fire = tok_q && ctl_i.step && ctl_i.poll && active_q && enabled_q &&
                (remaining_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q       <= 1'b0;
      active_q    <= 1'b0;
      enabled_q   <= 1'b0;
      period_q    <= '0;
      remaining_q <= '0;
      argument_q  <= '0;
      handler_q   <= '0;
    end else begin
      if (ctl_i.step) begin
        tok_q <= tok_i;
      end else if (ctl_i.clear) begin
        tok_q <= 1'b0;
      end

      if (take) begin
        active_q    <= 1'b1;
        enabled_q   <= 1'b1;
        period_q    <= ctl_i.period;
        remaining_q <= ctl_i.period;
        argument_q  <= ctl_i.argument;
        handler_q   <= ctl_i.handler;
      end else if (fire) begin
        remaining_q <= period_q;
      end else if (ctl_i.tick && active_q && (remaining_q != '0)) begin
        remaining_q <= remaining_q - VAL_W'(1);
      end

      if (sel_i && active_q) begin
        enabled_q <= ctl_i.en_val;
      end
    end
  end

  assign tok_o           = tok_q;
  assign stat_o.active   = active_q;
  assign stat_o.fire     = fire;
  assign stat_o.take     = take;
  assign stat_o.argument = fire ? argument_q : '0;
  assign stat_o.handler  = fire ? handler_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/ptss_seq.sv -----
// Sequencer of the scheduler: input handshake, token scan control, result
// staging and the output register. Depends on ptss_pkg.
`default_nettype none

module ptss_seq
  import ptss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  s_valid_i,
  output      logic  s_ready_o,
  input  wire item_t item_i,
  input  wire logic  live_i,      // addressed slot exists and is active
  input  wire cell_t cell_i,      // OR of all cell reports
  input  wire logic  last_tok_i,  // token sits in the last cell
  output      ctl_t  ctl_o,
  output      logic  m_valid_o,
  input  wire logic  m_ready_i,
  output      res_t  m_res_o,
  output      logic  m_last_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  res_t             pend_q, pend_d;
  logic             pend_v_q, pend_v_d;
  res_t             out_q, out_d;
  logic             out_v_q, out_v_d;
  logic             out_last_q, out_last_d;
  logic             out_free;
  logic             accept;
  logic             scan_op;
  res_t             res_blank;

  assign out_free  = !out_v_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE) && out_free;
  assign accept    = s_valid_i && s_ready_o;
  assign scan_op   = (item_i.opcode == OP_POLL) || (item_i.opcode == OP_ADD);

  always_comb begin
    res_blank        = '0;
    res_blank.status = ST_DONE;
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.start    = accept && scan_op;
    ctl_o.step     = ((state_q == S_SCAN) && out_free) || (accept && scan_op);
    ctl_o.clear    = (state_q != S_SCAN);
    ctl_o.tick     = accept && (item_i.opcode == OP_TICK);
    ctl_o.poll     = (state_q == S_SCAN) && (item_q.opcode == OP_POLL);
    ctl_o.add      = (state_q == S_SCAN) && (item_q.opcode == OP_ADD);
    ctl_o.en_val   = (item_i.opcode == OP_ENABLE);
    ctl_o.period   = item_q.period;
    ctl_o.argument = item_q.argument;
    ctl_o.handler  = item_q.handler;
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !m_ready_i;
    out_last_d = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d      = res_blank;
          out_last_d = 1'b1;
          case (item_i.opcode)
            OP_TICK: begin
              out_v_d = 1'b1;
            end
            OP_ENABLE, OP_DISABLE: begin
              out_d.status = live_i ? ST_DONE : ST_INACTIVE;
              out_v_d      = 1'b1;
            end
            OP_QUERY: begin
              out_d.is_active = live_i;
              out_v_d         = 1'b1;
            end
            OP_POLL, OP_ADD: begin
              item_d   = item_i;
              ptr_d    = '0;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              state_d  = S_SCAN;
            end
            default: begin
              // unknown opcode: swallowed without a result
              out_d = out_q;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (out_free) begin
          ptr_d = ptr_q + IDX_W'(1);
          if (cell_i.fire) begin
            if (pend_v_q) begin
              out_d      = pend_q;
              out_last_d = 1'b0;
              out_v_d    = 1'b1;
            end
            pend_d                = res_blank;
            pend_d.slot           = SLOT_W'(ptr_q);
            pend_d.fired_argument = cell_i.argument;
            pend_d.fired_handler  = cell_i.handler;
            pend_v_d              = 1'b1;
            cnt_d                 = cnt_q + CNT_W'(1);
            if (cnt_q == CNT_W'(MAX_RESULTS - 1)) begin
              state_d = S_FLUSH;
            end
          end
          if (cell_i.take) begin
            pend_d      = res_blank;
            pend_d.slot = SLOT_W'(ptr_q);
            pend_v_d    = 1'b1;
            state_d     = S_FLUSH;
          end
          if (last_tok_i) begin
            if (!pend_v_d) begin
              pend_d        = res_blank;
              pend_d.status = (item_q.opcode == OP_POLL) ? ST_IDLE : ST_FULL;
              pend_v_d      = 1'b1;
            end
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o = out_v_q;
  assign m_res_o   = out_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_task_slot_scheduler_top.sv -----
// Top level of the periodic task slot scheduler: a chain of SLOT_COUNT slot
// cells and the sequencer. Depends on ptss_pkg, ptss_cell and ptss_seq.
//
// Use:
//   Input words arrive on the s_axis stream, one operation per word (tick,
//   poll, add, enable, disable, query). Results leave on the m_axis stream;
//   m_axis_tlast marks the final result of an input word. Unknown opcodes are
//   taken and give no result.
// Flow:
//   Tick, enable, disable and query finish in the accepting cycle; the result
//   is registered in the output register and the next word can be taken in
//   the cycle after acceptance if m_axis_tready is high. Poll and add pass a
//   scan token down the slot chain one cell per cycle while the output
//   register can take results; add stops early when it finds a free slot,
//   and no new word is taken until the scan ends. A poll returns up to
//   MAX_RESULTS fired slots, in slot order.
// Reset:
//   rst_ni clears every slot (inactive, disabled, zero counts) and the output
//   valid flag; no sweep is needed, the block is ready once reset is released.
// Stall:
//   While m_axis_tready is low a waiting result holds; once the output
//   register is full the scan pauses in place and no new word is taken.
`default_nettype none

module periodic_task_slot_scheduler_top
  import ptss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // opcode[2:0], task_index[10:3], period[26:11], argument[42:27],
  // handler[58:43], zero[63:59]
  input  wire logic [63:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], slot[7:2], fired_argument[23:8], fired_handler[39:24],
  // is_active[40], zero[47:41]
  output      logic [47:0] m_axis_tdata,
  output      logic        m_axis_tlast
);

  item_t                 item;
  ctl_t                  ctl;
  cell_t                 stat [SLOT_COUNT];
  cell_t                 stat_or;
  logic [SLOT_COUNT-1:0] tok;
  logic [SLOT_COUNT-1:0] active;
  logic [SLOT_COUNT-1:0] sel;
  logic                  en_wr;
  logic                  live;
  res_t                  res;

  assign item  = item_t'(s_axis_tdata[IN_W-1:0]);
  assign en_wr = s_axis_tvalid && s_axis_tready &&
                 ((item.opcode == OP_ENABLE) || (item.opcode == OP_DISABLE));

  // out-of-range slot numbers count as inactive
  assign live = (item.task_index < 8'(SLOT_COUNT)) &&
                active[item.task_index[IDX_W-1:0]];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = ctl.start;   // injected on the start step only
    end else begin : g_link
      assign tok_in = tok[i-1];
    end
    assign sel[i]    = en_wr && (item.task_index == 8'(i));
    assign active[i] = stat[i].active;

    ptss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .tok_i  (tok_in),
      .sel_i  (sel[i]),
      .tok_o  (tok[i]),
      .stat_o (stat[i])
    );
  end

  // at most one cell fires or takes per cycle, so an OR merges their reports
  always_comb begin
    stat_or = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      stat_or = stat_or | stat[i];
    end
  end

  ptss_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .item_i     (item),
    .live_i     (live),
    .cell_i     (stat_or),
    .last_tok_i (tok[SLOT_COUNT-1]),
    .ctl_o      (ctl),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_res_o    (res),
    .m_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, res};

  // ---------------------------------------------------------------------
  // Assertions

  logic [SLOT_COUNT-1:0] fire_vec;
  logic [SLOT_COUNT-1:0] take_vec;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      fire_vec[i] = stat[i].fire;
      take_vec[i] = stat[i].take;
    end
  end

  // the scan token is never duplicated along the chain
  a_tok_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one scan token in the slot chain");

  // a poll or add launches the token into the first cell
  a_tok_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     ((item.opcode == OP_POLL) || (item.opcode == OP_ADD))) |=> tok[0])
    else $error("scan token not launched");

  // a slot can fire or be allocated, never both, and only one cell at a time
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({fire_vec, take_vec}))
    else $error("more than one cell acted on one scan step");

endmodule

`default_nettype wire

// ----- dv/ptss_slot_check.sv -----
// Slot table predictor and result checker for the periodic task slot scheduler.
// Watches both stream channels of the block; depends on ptss_pkg only.
module ptss_slot_check
  import ptss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic last;
    res_t word;
  } result_t;

  result_t pending_results[$];
  int      mismatches  = 0;
  int      queue_depth = 0;

  // shadow slot table
  logic             slot_act [SLOT_COUNT];
  logic             slot_en  [SLOT_COUNT];
  logic [VAL_W-1:0] slot_per [SLOT_COUNT];
  logic [VAL_W-1:0] slot_rem [SLOT_COUNT];
  logic [VAL_W-1:0] slot_arg [SLOT_COUNT];
  logic [VAL_W-1:0] slot_hnd [SLOT_COUNT];

  assign fail_count_o = mismatches;
  assign pending_o    = queue_depth;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, longint got, longint want);
    if (got != want) begin
      report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  function automatic result_t slot_result(status_e st, int slot, logic [VAL_W-1:0] arg,
                                          logic [VAL_W-1:0] hnd, logic act, logic last);
    result_t r;
    r.word.status         = st;
    r.word.slot           = SLOT_W'(slot);
    r.word.fired_argument = arg;
    r.word.fired_handler  = hnd;
    r.word.is_active      = act;
    r.last                = last;
    return r;
  endfunction

  // apply one accepted word to the shadow table, queue what it should return
  function automatic void schedule_step(item_t w);
    int idx;
    int fired;
    bit live;
    bit placed;
    idx    = int'(w.task_index);
    live   = 1'b0;
    fired  = 0;
    placed = 1'b0;
    if (idx < SLOT_COUNT) begin
      live = slot_act[idx];
    end
    case (w.opcode)
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_act[i] && slot_rem[i] != '0) slot_rem[i] = slot_rem[i] - 1'b1;
        end
        pending_results.push_back(slot_result(ST_DONE, 0, '0, '0, 1'b0, 1'b1));
      end
      OP_POLL: begin
        for (int i = 0; i < SLOT_COUNT && fired < MAX_RESULTS; i++) begin
          if (slot_act[i] && slot_en[i] && slot_rem[i] == '0) begin
            pending_results.push_back(slot_result(ST_DONE, i, slot_arg[i], slot_hnd[i],
                                                  1'b0, 1'b0));
            slot_rem[i] = slot_per[i];
            fired++;
          end
        end
        if (fired == 0) begin
          pending_results.push_back(slot_result(ST_IDLE, 0, '0, '0, 1'b0, 1'b1));
        end else begin
          pending_results[pending_results.size()-1].last = 1'b1;
        end
      end
      OP_ADD: begin
        for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
          if (!slot_act[i]) begin
            slot_act[i] = 1'b1;
            slot_en[i]  = 1'b1;
            slot_per[i] = w.period;
            slot_rem[i] = w.period;
            slot_arg[i] = w.argument;
            slot_hnd[i] = w.handler;
            placed      = 1'b1;
            pending_results.push_back(slot_result(ST_DONE, i, '0, '0, 1'b0, 1'b1));
          end
        end
        if (!placed) begin
          pending_results.push_back(slot_result(ST_FULL, 0, '0, '0, 1'b0, 1'b1));
        end
      end
      OP_ENABLE, OP_DISABLE: begin
        if (!live) begin
          pending_results.push_back(slot_result(ST_INACTIVE, 0, '0, '0, 1'b0, 1'b1));
        end else begin
          slot_en[idx] = (w.opcode == OP_ENABLE);
          pending_results.push_back(slot_result(ST_DONE, 0, '0, '0, 1'b0, 1'b1));
        end
      end
      OP_QUERY: begin
        pending_results.push_back(slot_result(ST_DONE, 0, '0, '0, live, 1'b1));
      end
      default: begin
        // opcodes 6 and 7: dropped, no result
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    res_t    got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_act[i] = 1'b0;
        slot_en[i]  = 1'b0;
        slot_per[i] = '0;
        slot_rem[i] = '0;
        slot_arg[i] = '0;
        slot_hnd[i] = '0;
      end
      pending_results.delete();
    end else begin
      // output first, so a word taken this edge cannot cover a stray result
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[OUT_W-1:0]);
        if (pending_results.size() == 0) begin
          report($sformatf("result word 0x%0h with nothing expected", m_tdata_i));
        end else begin
          want = pending_results.pop_front();
          compare_field("status", got.status, want.word.status);
          compare_field("slot", got.slot, want.word.slot);
          compare_field("fired_argument", got.fired_argument, want.word.fired_argument);
          compare_field("fired_handler", got.fired_handler, want.word.fired_handler);
          compare_field("is_active", got.is_active, want.word.is_active);
          compare_field("last", m_tlast_i, want.last);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        schedule_step(item_t'(s_tdata_i[IN_W-1:0]));
      end
    end
    queue_depth = pending_results.size();
  end

endmodule

// ----- dv/periodic_task_slot_scheduler_top_tb.sv -----
// Testbench top of the periodic task slot scheduler: clock, reset, stimulus and verdict.
// Depends on ptss_pkg, periodic_task_slot_scheduler_top and ptss_slot_check.
module periodic_task_slot_scheduler_top_tb;
  import ptss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  // long receiver hold-off, in cycles from time zero; lands in the random part
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 300;
  // quiet time after the last result: a full scan plus margin
  localparam int TAIL_CYCLES  = 4 * SLOT_COUNT + 20;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  int fail_count;
  int pending;

  always #1 clk_i = ~clk_i;

  periodic_task_slot_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ptss_slot_check u_slot_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic item_t op_item(op_e op, int idx, int per, int arg, int hnd);
    item_t w;
    w.opcode     = op;
    w.task_index = 8'(idx);
    w.period     = 16'(per);
    w.argument   = 16'(arg);
    w.handler    = 16'(hnd);
    return w;
  endfunction

  // Random word. Slot numbers mostly in range, periods mostly short so slots
  // come due often; ticks and polls dominate, as they drive the table.
  function automatic item_t rand_item();
    item_t w;
    int    pick;
    pick         = $urandom_range(0, 99);
    w.task_index = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                               : 8'($urandom_range(0, SLOT_COUNT - 1));
    w.period     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    w.argument   = 16'($urandom);
    w.handler    = 16'($urandom);
    if (pick < 34)      w.opcode = OP_TICK;
    else if (pick < 60) w.opcode = OP_POLL;
    else if (pick < 66) w.opcode = OP_ADD;
    else if (pick < 76) w.opcode = OP_ENABLE;
    else if (pick < 84) w.opcode = OP_DISABLE;
    else if (pick < 94) w.opcode = OP_QUERY;
    else                w.opcode = op_e'(3'($urandom_range(6, 7)));
    return w;
  endfunction

  // Offer one word, optionally after an idle gap; called and returns at a
  // falling edge. tvalid only drops when a gap is asked for, so it never
  // sees two assignments in one step.
  task automatic send_word(input item_t w, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, w};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Receiver: pattern is redrawn periodically from always ready, 50%,
  // 80% and 20% ready. One long hold-off lets the output register fill and
  // back-pressure the input while the sender keeps offering.
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 96 == 0) mode = $urandom_range(0, 3);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          2:       m_axis_tready <= ($urandom_range(0, 4) != 0);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int    accepted;
    int    burst;
    int    gap;
    bit    drained;
    item_t w;
    accepted = 0;
    drained  = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, back to back.
    // Empty table: query in and out of range, poll with nothing due, tick,
    // enable/disable of inactive and out-of-range slots.
    send_word(op_item(OP_QUERY, 0, 0, 0, 0), 0);
    send_word(op_item(OP_QUERY, 255, 16'hFFFF, -1, 16'hFFFF), 0);
    send_word(op_item(OP_POLL, 0, 0, 0, 0), 0);
    send_word(op_item(OP_TICK, 0, 0, 0, 0), 0);
    send_word(op_item(OP_ENABLE, 3, 0, 0, 0), 0);
    send_word(op_item(OP_DISABLE, 200, 0, 0, 0), 0);
    // Fill the table: period zero (due every poll) and field extremes first.
    send_word(op_item(OP_ADD, 0, 0, 32767, 0), 0);
    send_word(op_item(OP_ADD, 0, 16'hFFFF, -32768, 16'hFFFF), 0);
    send_word(op_item(OP_ADD, 0, 1, $urandom, $urandom), 0);
    send_word(op_item(OP_ADD, 0, 2, $urandom, $urandom), 0);
    send_word(op_item(OP_ADD, 0, 3, $urandom, $urandom), 0);
    send_word(op_item(OP_ADD, 0, 1, $urandom, $urandom), 0);
    send_word(op_item(OP_ADD, 0, 4, $urandom, $urandom), 0);
    send_word(op_item(OP_ADD, 0, 0, $urandom, $urandom), 0);
    // table full
    send_word(op_item(OP_ADD, 0, 7, 1234, 5678), 0);
    send_word(op_item(OP_QUERY, SLOT_COUNT - 1, 0, 0, 0), 0);
    send_word(op_item(OP_QUERY, SLOT_COUNT, 0, 0, 0), 0);
    // disabled slot still counts down on tick, but does not fire
    send_word(op_item(OP_DISABLE, 2, 0, 0, 0), 0);
    send_word(op_item(OP_POLL, 0, 0, 0, 0), 0);
    send_word(op_item(OP_TICK, 0, 0, 0, 0), 0);
    send_word(op_item(OP_TICK, 0, 0, 0, 0), 0);
    send_word(op_item(OP_POLL, 0, 0, 0, 0), 0);
    send_word(op_item(OP_ENABLE, 2, 0, 0, 0), 0);
    // unknown opcodes are swallowed
    send_word(op_item(op_e'(3'd6), 0, 0, 0, 0), 0);
    send_word(op_item(op_e'(3'd7), 255, 16'hFFFF, -1, 16'hFFFF), 0);
    send_word(op_item(OP_POLL, 0, 0, 0, 0), 0);

    // Random part in bursts with random gaps; some bursts have no gap.
    while (accepted < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < burst && accepted < RANDOM_ITEMS; k++) begin
        w = rand_item();
        send_word(w, (k == 0) ? gap : 0);
        if (3'(w.opcode) < 3'd6) accepted++;
      end
      // once, halfway: stop and let every outstanding result drain
      if (!drained && accepted >= RANDOM_ITEMS / 2) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
        drained = 1'b1;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ptss_pkg.sv
hw/rtl/ptss_cell.sv
hw/rtl/ptss_seq.sv
hw/rtl/periodic_task_slot_scheduler_top.sv
dv/ptss_slot_check.sv
dv/periodic_task_slot_scheduler_top_tb.sv
